FILE: design/sctb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_pkg
// Shared types, scan codes and escape sequence tables for the translator.
// ----------------------------------------------------------------------------
package sctb_pkg;

    localparam int KEYMAP_DEPTH = 1024;
    localparam int ADDR_W       = 10;
    localparam int CP_W         = 21;
    localparam int ENTRY_W      = CP_W + 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int BUF_LEN      = 5;

    // modifier flag bits
    localparam int FL_CTRL_L  = 0;
    localparam int FL_CTRL_R  = 1;
    localparam int FL_SHIFT_L = 2;
    localparam int FL_SHIFT_R = 3;
    localparam int FL_ALTGR   = 4;
    localparam int FL_NUMLOCK = 5;
    localparam int FL_SHLOCK  = 6;
    localparam int FL_ALT     = 7;

    // set-1 scan codes
    localparam logic [7:0] SC_PREFIX       = 8'hE0;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
    localparam logic [7:0] SC_NUMLOCK      = 8'h45;
    localparam logic [7:0] SC_CAPSLOCK     = 8'h3A;
    localparam logic [7:0] SC_PGUP         = 8'h49;
    localparam logic [7:0] SC_PGDN         = 8'h51;

    // result kinds
    localparam logic [1:0] KIND_DATA        = 2'd0;
    localparam logic [1:0] KIND_SCROLL_BACK = 2'd1;
    localparam logic [1:0] KIND_SCROLL_FWD  = 2'd2;

    localparam logic [7:0] ESC_BYTE = 8'h1B;

    // escape sequence ids
    localparam logic [4:0] ESC_INSERT = 5'd0;
    localparam logic [4:0] ESC_DELETE = 5'd1;
    localparam logic [4:0] ESC_HOME   = 5'd2;
    localparam logic [4:0] ESC_END    = 5'd3;
    localparam logic [4:0] ESC_UP     = 5'd4;
    localparam logic [4:0] ESC_DOWN   = 5'd5;
    localparam logic [4:0] ESC_LEFT   = 5'd6;
    localparam logic [4:0] ESC_RIGHT  = 5'd7;
    localparam logic [4:0] ESC_F1     = 5'd8;
    localparam logic [4:0] ESC_F2     = 5'd9;
    localparam logic [4:0] ESC_F3     = 5'd10;
    localparam logic [4:0] ESC_F4     = 5'd11;
    localparam logic [4:0] ESC_F5     = 5'd12;
    localparam logic [4:0] ESC_F6     = 5'd13;
    localparam logic [4:0] ESC_F7     = 5'd14;
    localparam logic [4:0] ESC_F8     = 5'd15;
    localparam logic [4:0] ESC_F9     = 5'd16;
    localparam logic [4:0] ESC_F10    = 5'd17;
    localparam logic [4:0] ESC_F11    = 5'd18;
    localparam logic [4:0] ESC_F12    = 5'd19;

    typedef struct packed {
        logic       hit;
        logic [4:0] id;
    } esc_hit_t;

    // chars[3] is the first byte after ESC
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] chars;
    } esc_seq_t;

    // request from front to back
    typedef struct packed {
        logic                is_write;
        logic [ADDR_W-1:0]   addr;
        logic [ENTRY_W-1:0]  wdata;
        logic [1:0]          scroll;
        logic                has_esc;
        logic [4:0]          esc_id;
        logic                lookup;
        logic                retry;
        logic                ctrl;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic esc_hit_t kp_lookup(input logic [7:0] c);
        esc_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            8'h52:   r.id = ESC_INSERT;
            8'h53:   r.id = ESC_DELETE;
            8'h47:   r.id = ESC_HOME;
            8'h4F:   r.id = ESC_END;
            8'h48:   r.id = ESC_UP;
            8'h50:   r.id = ESC_DOWN;
            8'h4B:   r.id = ESC_LEFT;
            8'h4D:   r.id = ESC_RIGHT;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic esc_hit_t fn_lookup(input logic [7:0] c);
        esc_hit_t r;
        r.hit = 1'b1;
        unique case (c)
            8'h3B:   r.id = ESC_F1;
            8'h3C:   r.id = ESC_F2;
            8'h3D:   r.id = ESC_F3;
            8'h3E:   r.id = ESC_F4;
            8'h3F:   r.id = ESC_F5;
            8'h40:   r.id = ESC_F6;
            8'h41:   r.id = ESC_F7;
            8'h42:   r.id = ESC_F8;
            8'h43:   r.id = ESC_F9;
            8'h44:   r.id = ESC_F10;
            8'h57:   r.id = ESC_F11;
            8'h58:   r.id = ESC_F12;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic esc_seq_t esc_seq(input logic [4:0] id);
        esc_seq_t s;
        unique case (id)
            ESC_INSERT: s = '{3'd3, {"[2~", 8'h00}};
            ESC_DELETE: s = '{3'd3, {"[3~", 8'h00}};
            ESC_HOME:   s = '{3'd2, {"OH", 16'h0000}};
            ESC_END:    s = '{3'd2, {"OF", 16'h0000}};
            ESC_UP:     s = '{3'd2, {"OA", 16'h0000}};
            ESC_DOWN:   s = '{3'd2, {"OB", 16'h0000}};
            ESC_LEFT:   s = '{3'd2, {"OD", 16'h0000}};
            ESC_RIGHT:  s = '{3'd2, {"OC", 16'h0000}};
            ESC_F1:     s = '{3'd2, {"OP", 16'h0000}};
            ESC_F2:     s = '{3'd2, {"OQ", 16'h0000}};
            ESC_F3:     s = '{3'd2, {"OR", 16'h0000}};
            ESC_F4:     s = '{3'd2, {"OS", 16'h0000}};
            ESC_F5:     s = '{3'd4, "[15~"};
            ESC_F6:     s = '{3'd4, "[17~"};
            ESC_F7:     s = '{3'd4, "[18~"};
            ESC_F8:     s = '{3'd4, "[19~"};
            ESC_F9:     s = '{3'd4, "[20~"};
            ESC_F10:    s = '{3'd4, "[21~"};
            ESC_F11:    s = '{3'd4, "[23~"};
            ESC_F12:    s = '{3'd4, "[24~"};
            default:    s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/sctb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_front
// Accepts requests, tracks prefix and modifier flags, classifies each scan
// code and pushes a request record into the queue.
// ----------------------------------------------------------------------------
module sctb_front
    import sctb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [7:0]         s_scan_code,
    input  logic [2:0]         s_entry_modifiers,
    input  logic [6:0]         s_entry_keycode,
    input  logic               s_entry_present,
    input  logic [CP_W-1:0]    s_entry_code_point,
    input  back_status_t       back_status,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_data
);

    logic [7:0] flags_reg, flags_next;
    logic       prefix_reg, prefix_next;
    logic       accept;
    logic       shift_held;
    logic       shift_eff;
    esc_hit_t   esc;
    cmd_t       cmd;

    assign s_ready = !q_full && !back_status.clearing;
    assign accept  = s_valid && s_ready;

    always_comb begin
        flags_next  = flags_reg;
        prefix_next = prefix_reg;
        esc         = '0;
        cmd         = '0;
        shift_held  = flags_reg[FL_SHIFT_L] | flags_reg[FL_SHIFT_R];
        shift_eff   = 1'b0;
        if (s_func) begin
            cmd.is_write = 1'b1;
            cmd.addr     = {s_entry_modifiers, s_entry_keycode};
            cmd.wdata    = s_entry_present ? {1'b1, s_entry_code_point} : '0;
        end else begin
            prefix_next = 1'b0;
            if (prefix_reg) begin
                unique case (s_scan_code)
                    SC_CTRL_MAKE:  flags_next[FL_CTRL_R] = 1'b1;
                    SC_CTRL_BREAK: flags_next[FL_CTRL_R] = 1'b0;
                    SC_ALT_MAKE:   flags_next[FL_ALTGR]  = 1'b1;
                    SC_ALT_BREAK:  flags_next[FL_ALTGR]  = 1'b0;
                    SC_PGUP:       if (shift_held) cmd.scroll = KIND_SCROLL_BACK;
                    SC_PGDN:       if (shift_held) cmd.scroll = KIND_SCROLL_FWD;
                    default:       esc = kp_lookup(s_scan_code);
                endcase
            end else begin
                unique case (s_scan_code)
                    SC_PREFIX:       prefix_next = 1'b1;
                    SC_CTRL_MAKE:    flags_next[FL_CTRL_L]  = 1'b1;
                    SC_CTRL_BREAK:   flags_next[FL_CTRL_L]  = 1'b0;
                    SC_LSHIFT_MAKE:  flags_next[FL_SHIFT_L] = 1'b1;
                    SC_LSHIFT_BREAK: flags_next[FL_SHIFT_L] = 1'b0;
                    SC_RSHIFT_MAKE:  flags_next[FL_SHIFT_R] = 1'b1;
                    SC_RSHIFT_BREAK: flags_next[FL_SHIFT_R] = 1'b0;
                    SC_ALT_MAKE:     flags_next[FL_ALT]     = 1'b1;
                    SC_ALT_BREAK:    flags_next[FL_ALT]     = 1'b0;
                    SC_NUMLOCK:      flags_next[FL_NUMLOCK] = !flags_reg[FL_NUMLOCK];
                    SC_CAPSLOCK:     flags_next[FL_SHLOCK]  = !flags_reg[FL_SHLOCK];
                    default: begin
                        esc = fn_lookup(s_scan_code);
                        // unprefixed keypad keys give sequences only with num lock off
                        if (!esc.hit && !flags_reg[FL_NUMLOCK]) begin
                            esc = kp_lookup(s_scan_code);
                        end
                    end
                endcase
            end
            shift_eff   = (flags_next[FL_SHIFT_L] | flags_next[FL_SHIFT_R])
                          ^ flags_next[FL_SHLOCK];
            cmd.addr    = {flags_next[FL_NUMLOCK], flags_next[FL_ALTGR], shift_eff,
                           s_scan_code[6:0]};
            cmd.has_esc = esc.hit;
            cmd.esc_id  = esc.id;
            cmd.lookup  = !esc.hit && !s_scan_code[7];
            cmd.retry   = flags_next[FL_NUMLOCK];
            cmd.ctrl    = (flags_next[FL_CTRL_L] | flags_next[FL_CTRL_R])
                          && !flags_next[FL_ALTGR];
        end
    end

    assign q_push = accept;
    assign q_data = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg  <= '0;
            prefix_reg <= 1'b0;
        end else if (accept) begin
            flags_reg  <= flags_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

FILE: design/sctb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_queue
// Small request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sctb_queue
    import sctb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: design/sctb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_back
// Owns the keymap memory: clears it after reset, applies table writes,
// performs lookups with num lock retry, encodes UTF-8 and emits results.
// ----------------------------------------------------------------------------
module sctb_back
    import sctb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_empty,
    input  cmd_t         q_data,
    output logic         q_pop,
    output back_status_t back_status,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_out_kind,
    output logic [7:0]   m_out_byte,
    output logic         m_last
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [1:0]         scroll_reg, scroll_next;
    logic               ctrl_reg, ctrl_next;
    logic               retry_reg, retry_next;
    logic [7:0]         buf_reg [BUF_LEN];
    logic [7:0]         buf_next [BUF_LEN];
    logic [1:0]         kind0_reg, kind0_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [2:0]         pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_kind_reg, m_kind_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;

    // keymap memory
    logic [ENTRY_W-1:0] mem [KEYMAP_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic               out_free;
    logic               hit;
    logic [CP_W-1:0]    cp;
    logic [7:0]         ub [4];
    logic [2:0]         ul;
    esc_seq_t           seq;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign back_status.clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !m_valid_reg || m_ready;

    // utf-8 encode of the looked-up entry, with the ctrl rule applied
    always_comb begin
        cp  = rd_data_reg[CP_W-1:0];
        hit = rd_data_reg[CP_W] && (cp != '0);
        ub[0] = 8'h00;
        ub[1] = 8'h00;
        ub[2] = 8'h00;
        ub[3] = 8'h00;
        if (cp < CP_W'(21'h80)) begin
            ub[0] = {1'b0, cp[6:0]};
            ul    = 3'd1;
        end else if (cp < CP_W'(21'h800)) begin
            ub[0] = {3'b110, cp[10:6]};
            ub[1] = {2'b10, cp[5:0]};
            ul    = 3'd2;
        end else if (cp < CP_W'(21'h10000)) begin
            ub[0] = {4'b1110, cp[15:12]};
            ub[1] = {2'b10, cp[11:6]};
            ub[2] = {2'b10, cp[5:0]};
            ul    = 3'd3;
        end else begin
            ub[0] = {5'b11110, cp[20:18]};
            ub[1] = {2'b10, cp[17:12]};
            ub[2] = {2'b10, cp[11:6]};
            ub[3] = {2'b10, cp[5:0]};
            ul    = 3'd4;
        end
        if (ctrl_reg) begin
            priority if (ub[0] >= 8'h61 && ub[0] <= 8'h7A) begin
                ub[0] = ub[0] - 8'h60;
                ul    = 3'd1;
            end else if (ub[0] >= 8'h41 && ub[0] <= 8'h5A) begin
                ub[0] = ub[0] - 8'h40;
                ul    = 3'd1;
            end else begin
                ul    = 3'd0;
            end
        end
        if (!hit) begin
            ul = 3'd0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        scroll_next  = scroll_reg;
        ctrl_next    = ctrl_reg;
        retry_next   = retry_reg;
        kind0_next   = kind0_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        for (int i = 0; i < BUF_LEN; i++) begin
            buf_next[i] = buf_reg[i];
        end
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = q_data.addr;
        mem_wdata    = q_data.wdata;
        mem_re       = 1'b0;
        mem_raddr    = q_data.addr;
        seq          = esc_seq(q_data.esc_id);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(KEYMAP_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    addr_next   = q_data.addr;
                    scroll_next = q_data.scroll;
                    ctrl_next   = q_data.ctrl;
                    retry_next  = q_data.retry;
                    if (q_data.is_write) begin
                        mem_we = 1'b1;
                    end else if (q_data.has_esc) begin
                        buf_next[0] = ESC_BYTE;
                        buf_next[1] = seq.chars[3];
                        buf_next[2] = seq.chars[2];
                        buf_next[3] = seq.chars[1];
                        buf_next[4] = seq.chars[0];
                        kind0_next  = KIND_DATA;
                        cnt_next    = seq.len + 3'd1;
                        pos_next    = '0;
                        state_next  = ST_EMIT;
                    end else if (q_data.lookup) begin
                        mem_re     = 1'b1;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (!rd_data_reg[CP_W] && retry_reg) begin
                    // miss with num lock: try again without it
                    mem_re     = 1'b1;
                    mem_raddr  = {1'b0, addr_reg[ADDR_W-2:0]};
                    retry_next = 1'b0;
                end else begin
                    pos_next = '0;
                    if (scroll_reg != KIND_DATA) begin
                        buf_next[0] = 8'h00;
                        buf_next[1] = ub[0];
                        buf_next[2] = ub[1];
                        buf_next[3] = ub[2];
                        buf_next[4] = ub[3];
                        kind0_next  = scroll_reg;
                        cnt_next    = ul + 3'd1;
                        state_next  = ST_EMIT;
                    end else begin
                        buf_next[0] = ub[0];
                        buf_next[1] = ub[1];
                        buf_next[2] = ub[2];
                        buf_next[3] = ub[3];
                        buf_next[4] = 8'h00;
                        kind0_next  = KIND_DATA;
                        cnt_next    = ul;
                        state_next  = (ul == 3'd0) ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = (pos_reg == 3'd0) ? kind0_reg : KIND_DATA;
                    m_byte_next  = buf_reg[pos_reg];
                    m_last_next  = (pos_reg == cnt_reg - 3'd1);
                    pos_next     = pos_reg + 3'd1;
                    if (pos_reg == cnt_reg - 3'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg   <= addr_next;
        scroll_reg <= scroll_next;
        ctrl_reg   <= ctrl_next;
        retry_reg  <= retry_next;
        kind0_reg  <= kind0_next;
        cnt_reg    <= cnt_next;
        pos_reg    <= pos_next;
        for (int i = 0; i < BUF_LEN; i++) begin
            buf_reg[i] <= buf_next[i];
        end
        m_kind_reg <= m_kind_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_kind = m_kind_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

FILE: design/scan_code_to_terminal_bytes.sv
`timescale 1ns / 1ps
// Flow: an escape sequence goes from the queue through ST_IDLE and ST_EMIT to the
// output register; a keymap hit also passes ST_LOOK, with a second read there when
// the lookup retries without num lock; a table write is applied in ST_IDLE. The back
// end handles one request at a time and pops the next only after its last byte.
// Reset: synchronous active low; afterwards a pass clears all 1024 keymap entries
// with s_ready held low.
// ----------------------------------------------------------------------------
// scan_code_to_terminal_bytes
// Set-1 scan code to terminal byte translator: front classifier, request
// queue and back end with keymap memory and UTF-8 encoder.
// ----------------------------------------------------------------------------
module scan_code_to_terminal_bytes
    import sctb_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    input  logic [7:0]      s_scan_code,
    input  logic [2:0]      s_entry_modifiers,
    input  logic [6:0]      s_entry_keycode,
    input  logic            s_entry_present,
    input  logic [CP_W-1:0] s_entry_code_point,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_out_kind,
    output logic [7:0]      m_out_byte,
    output logic            m_last
);

    back_status_t back_status;
    logic         q_full, q_push, q_pop, q_empty;
    cmd_t         q_in, q_out;

    sctb_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_scan_code        (s_scan_code),
        .s_entry_modifiers  (s_entry_modifiers),
        .s_entry_keycode    (s_entry_keycode),
        .s_entry_present    (s_entry_present),
        .s_entry_code_point (s_entry_code_point),
        .back_status        (back_status),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_data             (q_in)
    );

    sctb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    sctb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last)
    );

endmodule

FILE: design/sctb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctb_checker
// Port-level checks for the translator, bound to the top level.
// ----------------------------------------------------------------------------
module sctb_checker
    import sctb_pkg::*;
(
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            s_func,
    input logic [7:0]      s_scan_code,
    input logic [2:0]      s_entry_modifiers,
    input logic [6:0]      s_entry_keycode,
    input logic            s_entry_present,
    input logic [CP_W-1:0] s_entry_code_point,
    input logic            m_valid,
    input logic            m_ready,
    input logic [1:0]      m_out_kind,
    input logic [7:0]      m_out_byte,
    input logic            m_last
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // keymap clear keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during keymap clear");

    a_scroll_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind != KIND_DATA) |-> (m_out_byte == 8'h00))
        else $error("scroll request with nonzero byte");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_kind != 2'd3))
        else $error("undefined result kind");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind scan_code_to_terminal_bytes sctb_checker u_sctb_checker (.*);

FILE: tb/term_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// term_check_pkg
// Expected-byte tracking for the scan code translator testbench: a copy of
// the keymap and modifier state that turns each request into terminal bytes.
// ----------------------------------------------------------------------------
package term_check_pkg;
    import sctb_pkg::*;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } term_byte_t;

    class term_byte_scoreboard;
        logic [ENTRY_W-1:0] keymap [KEYMAP_DEPTH];
        logic [7:0]         flags;
        bit                 prefix_seen;
        term_byte_t         expected_bytes [$];
        int                 errors;

        function new();
            foreach (keymap[i]) keymap[i] = '0;
            flags       = '0;
            prefix_seen = 1'b0;
            errors      = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void queue_byte(logic [1:0] kind, logic [7:0] data);
            term_byte_t t;
            t.kind = kind;
            t.data = data;
            t.last = 1'b0;
            expected_bytes.push_back(t);
        endfunction

        function string keypad_seq(logic [7:0] code);
            case (code)
                8'h52:   return "[2~";
                8'h53:   return "[3~";
                8'h47:   return "OH";
                8'h4F:   return "OF";
                8'h48:   return "OA";
                8'h50:   return "OB";
                8'h4B:   return "OD";
                8'h4D:   return "OC";
                default: return "";
            endcase
        endfunction

        function string fkey_seq(logic [7:0] code);
            case (code)
                8'h3B:   return "OP";
                8'h3C:   return "OQ";
                8'h3D:   return "OR";
                8'h3E:   return "OS";
                8'h3F:   return "[15~";
                8'h40:   return "[17~";
                8'h41:   return "[18~";
                8'h42:   return "[19~";
                8'h43:   return "[20~";
                8'h44:   return "[21~";
                8'h57:   return "[23~";
                8'h58:   return "[24~";
                default: return "";
            endcase
        endfunction

        // work out the bytes one accepted request produces
        function void note_request(logic func, logic [7:0] code, logic [2:0] mods,
                                   logic [6:0] kc, logic present, logic [CP_W-1:0] cp);
            string              seq;
            int                 first;
            int                 len;
            logic [2:0]         mask;
            logic [ENTRY_W-1:0] e;
            logic [CP_W-1:0]    v;
            logic [7:0]         b [4];
            term_byte_t         t;
            first = expected_bytes.size();
            seq   = "";
            if (func) begin
                keymap[{mods, kc}] = present ? {1'b1, cp} : '0;
                return;
            end
            if (prefix_seen) begin
                prefix_seen = 1'b0;
                case (code)
                    SC_CTRL_MAKE:  flags[FL_CTRL_R] = 1'b1;
                    SC_CTRL_BREAK: flags[FL_CTRL_R] = 1'b0;
                    SC_ALT_MAKE:   flags[FL_ALTGR]  = 1'b1;
                    SC_ALT_BREAK:  flags[FL_ALTGR]  = 1'b0;
                    SC_PGUP: begin
                        if (flags[FL_SHIFT_L] || flags[FL_SHIFT_R])
                            queue_byte(KIND_SCROLL_BACK, 8'h00);
                    end
                    SC_PGDN: begin
                        if (flags[FL_SHIFT_L] || flags[FL_SHIFT_R])
                            queue_byte(KIND_SCROLL_FWD, 8'h00);
                    end
                    default: seq = keypad_seq(code);
                endcase
            end else begin
                case (code)
                    SC_PREFIX:       prefix_seen = 1'b1;
                    SC_CTRL_MAKE:    flags[FL_CTRL_L]  = 1'b1;
                    SC_CTRL_BREAK:   flags[FL_CTRL_L]  = 1'b0;
                    SC_LSHIFT_MAKE:  flags[FL_SHIFT_L] = 1'b1;
                    SC_LSHIFT_BREAK: flags[FL_SHIFT_L] = 1'b0;
                    SC_RSHIFT_MAKE:  flags[FL_SHIFT_R] = 1'b1;
                    SC_RSHIFT_BREAK: flags[FL_SHIFT_R] = 1'b0;
                    SC_ALT_MAKE:     flags[FL_ALT]     = 1'b1;
                    SC_ALT_BREAK:    flags[FL_ALT]     = 1'b0;
                    SC_NUMLOCK:      flags[FL_NUMLOCK] = ~flags[FL_NUMLOCK];
                    SC_CAPSLOCK:     flags[FL_SHLOCK]  = ~flags[FL_SHLOCK];
                    default: begin
                        seq = fkey_seq(code);
                        if (seq.len() == 0 && !flags[FL_NUMLOCK])
                            seq = keypad_seq(code);
                    end
                endcase
            end

            if (seq.len() > 0) begin
                queue_byte(KIND_DATA, ESC_BYTE);
                for (int i = 0; i < seq.len(); i++)
                    queue_byte(KIND_DATA, seq[i]);
            end else if (!code[7]) begin
                // shift lock inverts the shift bit of the mask
                mask = {flags[FL_NUMLOCK], flags[FL_ALTGR],
                        (flags[FL_SHIFT_L] | flags[FL_SHIFT_R]) ^ flags[FL_SHLOCK]};
                e = keymap[{mask, code[6:0]}];
                if (!e[CP_W] && flags[FL_NUMLOCK])
                    e = keymap[{1'b0, mask[1:0], code[6:0]}];
                v = e[CP_W-1:0];
                if (e[CP_W] && v != '0) begin
                    if (v < 21'h80) begin
                        b[0] = {1'b0, v[6:0]};
                        len  = 1;
                    end else if (v < 21'h800) begin
                        b[0] = {3'b110, v[10:6]};
                        b[1] = {2'b10, v[5:0]};
                        len  = 2;
                    end else if (v < 21'h10000) begin
                        b[0] = {4'b1110, v[15:12]};
                        b[1] = {2'b10, v[11:6]};
                        b[2] = {2'b10, v[5:0]};
                        len  = 3;
                    end else begin
                        b[0] = {5'b11110, v[20:18]};
                        b[1] = {2'b10, v[17:12]};
                        b[2] = {2'b10, v[11:6]};
                        b[3] = {2'b10, v[5:0]};
                        len  = 4;
                    end
                    if ((flags[FL_CTRL_L] || flags[FL_CTRL_R]) && !flags[FL_ALTGR]) begin
                        // ctrl maps letters a..z / A..Z to 1..26, drops the rest
                        if (b[0] >= 8'h61 && b[0] <= 8'h7A)
                            queue_byte(KIND_DATA, b[0] - 8'h60);
                        else if (b[0] >= 8'h41 && b[0] <= 8'h5A)
                            queue_byte(KIND_DATA, b[0] - 8'h40);
                    end else begin
                        for (int i = 0; i < len; i++)
                            queue_byte(KIND_DATA, b[i]);
                    end
                end
            end

            if (expected_bytes.size() > first) begin
                t = expected_bytes.pop_back();
                t.last = 1'b1;
                expected_bytes.push_back(t);
            end
        endfunction

        task check_result(logic [1:0] kind, logic [7:0] data, logic last);
            term_byte_t t;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected result kind %0d byte %02h last %0b",
                                 kind, data, last));
                return;
            end
            t = expected_bytes.pop_front();
            if (kind !== t.kind)
                report($sformatf("out_kind %0d, wanted %0d", kind, t.kind));
            if (data !== t.data)
                report($sformatf("out_byte %02h, wanted %02h", data, t.data));
            if (last !== t.last)
                report($sformatf("last %0b, wanted %0b", last, t.last));
        endtask
    endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives scan codes and keymap writes into the translator with random gaps
// and output stalls, and checks every terminal byte against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
    import sctb_pkg::*;
    import term_check_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic            aclk               = 1'b0;
    logic            aresetn            = 1'b0;
    logic            s_valid            = 1'b0;
    logic            s_ready;
    logic            s_func             = 1'b0;
    logic [7:0]      s_scan_code        = '0;
    logic [2:0]      s_entry_modifiers  = '0;
    logic [6:0]      s_entry_keycode    = '0;
    logic            s_entry_present    = 1'b0;
    logic [CP_W-1:0] s_entry_code_point = '0;
    logic            m_valid;
    logic            m_ready            = 1'b0;
    logic [1:0]      m_out_kind;
    logic [7:0]      m_out_byte;
    logic            m_last;

    int send_idle_pct = 23;
    int recv_idle_pct = 75;
    int items_sent    = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    term_byte_scoreboard sb = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    scan_code_to_terminal_bytes i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_scan_code        (s_scan_code),
        .s_entry_modifiers  (s_entry_modifiers),
        .s_entry_keycode    (s_entry_keycode),
        .s_entry_present    (s_entry_present),
        .s_entry_code_point (s_entry_code_point),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_kind         (m_out_kind),
        .m_out_byte         (m_out_byte),
        .m_last             (m_last)
    );

    // output side: random stalls, plus one long hold so the request queue fills
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_kind, m_out_byte, m_last);
    end

    task automatic send_request(logic func, logic [7:0] code, logic [2:0] mods,
                                logic [6:0] kc, logic present, logic [CP_W-1:0] cp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_func             <= func;
        s_scan_code        <= code;
        s_entry_modifiers  <= mods;
        s_entry_keycode    <= kc;
        s_entry_present    <= present;
        s_entry_code_point <= cp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(func, code, mods, kc, present, cp);
        items_sent++;
    endtask

    // unused entry fields carry random values
    task automatic send_scan(logic [7:0] code);
        send_request(1'b0, code, 3'($urandom_range(7)), 7'($urandom_range(127)),
                     1'($urandom_range(1)), CP_W'($urandom_range(21'h1FFFFF)));
    endtask

    task automatic send_entry(logic [2:0] mods, logic [6:0] kc, logic present,
                              logic [CP_W-1:0] cp);
        send_request(1'b1, 8'($urandom_range(255)), mods, kc, present, cp);
    endtask

    function automatic logic [CP_W-1:0] random_code_point();
        case ($urandom_range(5))
            0, 1:    return CP_W'($urandom_range(8'h7E, 8'h20));
            2:       return CP_W'($urandom_range(12'h7FF, 12'h080));
            3:       return CP_W'($urandom_range(16'hFFFF, 16'h0800));
            4:       return CP_W'($urandom_range(21'h1FFFFF, 21'h10000));
            default: return CP_W'($urandom_range(127));
        endcase
    endfunction

    // keys that the keymap writes target, so lookups hit often
    function automatic logic [6:0] pool_key();
        if ($urandom_range(9) < 6)
            return 7'($urandom_range(8'h1F, 8'h10));
        return 7'($urandom_range(8'h53, 8'h47));
    endfunction

    task automatic random_step();
        int         r;
        logic [7:0] key;
        r = $urandom_range(99);
        if (r < 18) begin
            send_entry(3'($urandom_range(7)),
                       ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : pool_key(),
                       1'($urandom_range(6) != 0), random_code_point());
        end else if (r < 50) begin
            key = {1'b0, pool_key()};
            send_scan(key);
            if ($urandom_range(9) < 3)
                send_scan(key | 8'h80);
        end else if (r < 68) begin
            case ($urandom_range(10))
                0:       key = SC_CTRL_MAKE;
                1:       key = SC_CTRL_BREAK;
                2:       key = SC_LSHIFT_MAKE;
                3:       key = SC_LSHIFT_BREAK;
                4:       key = SC_RSHIFT_MAKE;
                5:       key = SC_RSHIFT_BREAK;
                6:       key = SC_ALT_MAKE;
                7:       key = SC_ALT_BREAK;
                8:       key = SC_NUMLOCK;
                9:       key = SC_CAPSLOCK;
                default: key = SC_CTRL_BREAK;
            endcase
            send_scan(key);
        end else if (r < 80) begin
            send_scan(SC_PREFIX);
            case ($urandom_range(7))
                0:       key = SC_CTRL_MAKE;
                1:       key = SC_CTRL_BREAK;
                2:       key = SC_ALT_MAKE;
                3:       key = SC_ALT_BREAK;
                4:       key = SC_PGUP;
                5:       key = SC_PGDN;
                6:       key = 8'($urandom_range(8'h53, 8'h47));
                default: key = 8'($urandom_range(255));
            endcase
            send_scan(key);
        end else if (r < 90) begin
            if ($urandom_range(5) == 0)
                key = $urandom_range(1) ? 8'h57 : 8'h58;
            else
                key = 8'($urandom_range(8'h44, 8'h3B));
            send_scan(key);
        end else begin
            send_scan(8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // keymap entries: plain, shifted, every UTF-8 length, silent keypad key
        send_entry(3'd0, 7'h1E, 1'b1, 21'h000061);
        send_entry(3'd1, 7'h1E, 1'b1, 21'h000041);
        send_entry(3'd0, 7'h10, 1'b1, 21'h1FFFFF);
        send_entry(3'd2, 7'h10, 1'b1, 21'h0020AC);
        send_entry(3'd0, 7'h11, 1'b1, 21'h0000E9);
        send_entry(3'd4, 7'h47, 1'b1, 21'h000000);
        send_scan(8'h1E);
        send_scan(8'h10);
        send_scan(8'h11);
        send_scan(SC_LSHIFT_MAKE);
        send_scan(8'h1E);
        send_scan(SC_PREFIX);
        send_scan(SC_PGUP);
        send_scan(SC_PREFIX);
        send_scan(SC_PGDN);
        send_scan(SC_LSHIFT_BREAK);
        send_scan(8'h58);
        send_scan(8'h47);
        // num lock on: silent entry blocks the retry, missing entry retries
        send_scan(SC_NUMLOCK);
        send_scan(8'h47);
        send_scan(8'h11);
        send_scan(SC_CTRL_MAKE);
        send_scan(8'h1E);
        send_scan(8'h11);
        send_scan(SC_PREFIX);
        send_scan(8'hFF);

        while (items_sent < 95) random_step();
        send_idle_pct = 75;
        recv_idle_pct = 23;
        while (items_sent < 160) random_step();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        while (items_sent < 225) random_step();
        s_valid <= 1'b0;

        for (int w = 0; w < 20000 && sb.expected_bytes.size() != 0; w++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.expected_bytes.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_bytes.size()));

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/sctb_pkg.sv
design/sctb_front.sv
design/sctb_queue.sv
design/sctb_back.sv
design/scan_code_to_terminal_bytes.sv
design/sctb_checker.sv
tb/term_check_pkg.sv
tb/tb.sv
